FILE: rtl/core/pfd_pkg.sv
// Shared types and constants for the PLL frequency decode pipeline.
`timescale 1ns / 1ps
package pfd_pkg;

    localparam int WORD_W     = 32;
    localparam int REF_W      = 31;
    localparam int FREQ_W     = 32;
    localparam int MFN_W      = 10;
    localparam int MFI_W      = 4;
    localparam int MFD_W      = 10;
    localparam int PD_W       = 4;
    localparam int PROD_W     = FREQ_W + MFN_W;
    localparam int PD_DEN_W   = PD_W + 1;
    localparam int MFD_DEN_W  = MFD_W + 1;

    localparam int MFN_LSB    = 0;
    localparam int MFI_LSB    = 10;
    localparam int MFD_LSB    = 16;
    localparam int PD_LSB     = 26;

    localparam logic [MFN_W-1:0] MFN_SIGN = 10'h200;
    localparam logic [MFI_W-1:0] MFI_MIN  = 4'd5;

    // fields carried alongside the reference divider
    typedef struct packed {
        logic [MFD_W-1:0] mfd;
        logic             neg;
        logic [MFI_W-1:0] mfi;
        logic [MFN_W-1:0] mag;
    } t_fields;

    // fields carried alongside the fraction divider
    typedef struct packed {
        logic [FREQ_W-1:0] whole;
        logic              neg;
    } t_frac_side;

endpackage

FILE: rtl/core/pll_frequency_decode.sv
// Top level: fractional-N PLL output frequency decode pipeline.
// Stages from an accepted input beat to its result beat, in order: unpack,
// reference divider, multiply, fraction divider, sum.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous, active low; clears all valid bits, sets signed mode to 1.
`timescale 1ns / 1ps
module pll_frequency_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [pfd_pkg::WORD_W-1:0] i_pll_control_word,
    input  logic [pfd_pkg::REF_W-1:0]  i_reference_frequency,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [pfd_pkg::FREQ_W-1:0] o_output_frequency,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_data
);
    import pfd_pkg::*;

    logic                  en;
    logic                  r_signed_mode;

    logic                  r_up_valid;
    logic [FREQ_W-1:0]     r_up_num;
    logic [PD_DEN_W-1:0]   r_up_den;
    t_fields               r_up_fields;
    t_fields               n_fields;
    logic [MFN_W-1:0]      mfn;
    logic [MFI_W-1:0]      mfi;
    logic [PD_W-1:0]       pd;

    logic                  rd_valid;
    logic [FREQ_W-1:0]     rd_quot;
    logic [$bits(t_fields)-1:0] rd_side;

    logic                  sc_valid;
    logic [PROD_W-1:0]     sc_prod;
    logic [MFD_DEN_W-1:0]  sc_den;
    t_frac_side            sc_side;

    logic                  fd_valid;
    logic [PROD_W-1:0]     fd_quot;
    logic [$bits(t_frac_side)-1:0] fd_side_raw;
    t_frac_side            fd_side;

    logic                  r_out_valid;
    logic [FREQ_W-1:0]     r_out_freq;
    logic [FREQ_W-1:0]     n_out_freq;

    assign en          = !r_out_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_signed_mode <= i_cfg_data;
        end
    end

    // unpack
    always_comb begin
        mfn            = i_pll_control_word[MFN_LSB +: MFN_W];
        mfi            = i_pll_control_word[MFI_LSB +: MFI_W];
        pd             = i_pll_control_word[PD_LSB +: PD_W];
        n_fields.mfd   = i_pll_control_word[MFD_LSB +: MFD_W];
        n_fields.neg   = r_signed_mode && (mfn >= MFN_SIGN);
        n_fields.mag   = n_fields.neg ? (~mfn + 10'd1) : mfn;
        n_fields.mfi   = (mfi < MFI_MIN) ? MFI_MIN : mfi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_valid <= 1'b0;
        end else if (en) begin
            r_up_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_up_num    <= {i_reference_frequency, 1'b0};
            r_up_den    <= {1'b0, pd} + 5'd1;
            r_up_fields <= n_fields;
        end
    end

    pfd_pipe_div #(
        .N_W (FREQ_W),
        .D_W (PD_DEN_W),
        .S_W ($bits(t_fields))
    ) u_ref_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_up_valid),
        .i_num   (r_up_num),
        .i_den   (r_up_den),
        .i_side  (r_up_fields),
        .o_valid (rd_valid),
        .o_quot  (rd_quot),
        .o_side  (rd_side)
    );

    pfd_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (rd_valid),
        .i_freq   (rd_quot),
        .i_fields (t_fields'(rd_side)),
        .o_valid  (sc_valid),
        .o_prod   (sc_prod),
        .o_den    (sc_den),
        .o_side   (sc_side)
    );

    pfd_pipe_div #(
        .N_W (PROD_W),
        .D_W (MFD_DEN_W),
        .S_W ($bits(t_frac_side))
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sc_valid),
        .i_num   (sc_prod),
        .i_den   (sc_den),
        .i_side  (sc_side),
        .o_valid (fd_valid),
        .o_quot  (fd_quot),
        .o_side  (fd_side_raw)
    );

    assign fd_side = t_frac_side'(fd_side_raw);

    // fraction truncated to 32 bits, sum wraps
    always_comb begin
        if (fd_side.neg) begin
            n_out_freq = fd_side.whole - fd_quot[FREQ_W-1:0];
        end else begin
            n_out_freq = fd_side.whole + fd_quot[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_freq <= n_out_freq;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_output_frequency = r_out_freq;

endmodule

FILE: rtl/core/pfd_pipe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module pfd_pipe_div #(
    parameter int N_W = 32,
    parameter int D_W = 5,
    parameter int S_W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  logic [S_W-1:0] i_side,
    output logic           o_valid,
    output logic [N_W-1:0] o_quot,
    output logic [S_W-1:0] o_side
);

    logic [D_W-1:0] r_rem  [N_W];
    logic [N_W-1:0] r_qn   [N_W];
    logic [D_W-1:0] r_den  [N_W];
    logic [S_W-1:0] r_side [N_W];
    logic           r_vld  [N_W];

    genvar g;
    for (g = 0; g < N_W; g++) begin : g_stage
        logic [D_W-1:0] p_rem;
        logic [N_W-1:0] p_qn;
        logic [D_W-1:0] p_den;
        logic [S_W-1:0] p_side;
        logic           p_vld;
        logic [D_W:0]   t;
        logic           ge;
        logic [D_W:0]   diff;
        logic [D_W-1:0] n_rem;
        logic [N_W-1:0] n_qn;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_qn   = i_num;
            assign p_den  = i_den;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_qn   = r_qn[g-1];
            assign p_den  = r_den[g-1];
            assign p_side = r_side[g-1];
            assign p_vld  = r_vld[g-1];
        end

        always_comb begin
            t     = {p_rem, p_qn[N_W-1]};
            diff  = t - {1'b0, p_den};
            ge    = (t >= {1'b0, p_den});
            n_rem = ge ? diff[D_W-1:0] : t[D_W-1:0];
            n_qn  = {p_qn[N_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_qn[g]   <= n_qn;
                r_den[g]  <= p_den;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[N_W-1];
    assign o_quot  = r_qn[N_W-1];
    assign o_side  = r_side[N_W-1];

endmodule

FILE: rtl/core/pfd_scale.sv
// Multiply stage: f times fraction magnitude and f times integer multiplier.
`timescale 1ns / 1ps
module pfd_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [pfd_pkg::FREQ_W-1:0] i_freq,
    input  pfd_pkg::t_fields           i_fields,
    output logic                       o_valid,
    output logic [pfd_pkg::PROD_W-1:0] o_prod,
    output logic [pfd_pkg::MFD_DEN_W-1:0] o_den,
    output pfd_pkg::t_frac_side        o_side
);
    import pfd_pkg::*;

    logic                  r_valid;
    logic [PROD_W-1:0]     r_prod;
    logic [MFD_DEN_W-1:0]  r_den;
    t_frac_side            r_side;
    logic [PROD_W-1:0]     n_prod;
    logic [FREQ_W+MFI_W-1:0] n_whole_full;

    always_comb begin
        n_prod       = {{MFN_W{1'b0}}, i_freq} * {{FREQ_W{1'b0}}, i_fields.mag};
        n_whole_full = {{MFI_W{1'b0}}, i_freq} * {{FREQ_W{1'b0}}, i_fields.mfi};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod       <= n_prod;
            r_den        <= {1'b0, i_fields.mfd} + 11'd1;
            r_side.whole <= n_whole_full[FREQ_W-1:0];
            r_side.neg   <= i_fields.neg;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule
